FILE: sv/active_set_cycle_detector_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the active-set cycle detector
// Wraps concurrent assertions on aclk with a synchronous active-low reset;
// the bodies are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ACTIVE_SET_CYCLE_DETECTOR_MACROS_SVH
`define ACTIVE_SET_CYCLE_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Holds at every clock edge outside reset.
`define ASC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("asc: invariant violated");
// Antecedent in one cycle implies the consequent in the same cycle.
`define ASC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("asc: implication violated");
// Antecedent in one cycle implies the consequent in the next cycle.
`define ASC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("asc: next-cycle implication violated");
`else
`define ASC_ASSERT_ALWAYS(label, expr)
`define ASC_ASSERT_IMP(label, ante, cons)
`define ASC_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: sv/asc_pkg.sv
// ----------------------------------------------------------------------------
// Active-set cycle detector package
// Shared constants, sequencer types and the microcode ROM.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int NODE_COUNT_DEF = 8;
    localparam int STEP_COUNT_DEF = 16;

    localparam int MAX_NODES = 8;   // width of every node mask and row
    localparam int NODE_W    = 3;   // node identifier
    localparam int CNT_W     = 4;   // holds 0..MAX_NODES (depth, scan counters)
    localparam int OP_W      = 2;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int TOTAL_W   = 16;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 32;

    localparam logic [TOTAL_W-1:0] COUNTER_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_FALSE    = 2'd0,
        OP_ACTIVATE = 2'd1,
        OP_UNDO     = 2'd2
    } op_t;

    // Microprogram addresses.
    typedef enum logic [2:0] {
        P_WAIT, P_LOAD, P_CLEAR, P_ROOT, P_EDGE, P_TRACE, P_FOUND, P_EMIT
    } upc_t;

    // Datapath actions.
    typedef enum logic [3:0] {
        A_NONE, A_ACCEPT, A_UPDATE, A_CLEAR, A_ROOT, A_EDGE, A_TRACE, A_FOUND, A_EMIT
    } act_t;

    // Branch condition selectors.
    typedef enum logic [3:0] {
        C_NEVER, C_IN_VALID, C_ACTIVATE, C_FEW, C_ROOT_END, C_ROOT_START,
        C_BACK, C_LAST_POP, C_TRACE_HIT, C_OUT_BUSY
    } cond_sel_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic activate;
        logic few;
        logic root_end;
        logic root_start;
        logic back;
        logic last_pop;
        logic trace_hit;
        logic out_busy;
    } cond_t;

    // One control word: action, two prioritized branches, fall-through target.
    typedef struct packed {
        act_t      act;
        cond_sel_t c1;
        upc_t      t1;
        cond_sel_t c2;
        upc_t      t2;
        upc_t      tn;
    } ctrl_t;

    function automatic ctrl_t ucode(upc_t pc);
        ctrl_t w;
        unique case (pc)
            P_WAIT:  w = '{A_ACCEPT, C_IN_VALID,  P_LOAD,  C_NEVER,      P_WAIT, P_WAIT};
            P_LOAD:  w = '{A_UPDATE, C_ACTIVATE,  P_CLEAR, C_NEVER,      P_EMIT, P_EMIT};
            P_CLEAR: w = '{A_CLEAR,  C_FEW,       P_EMIT,  C_NEVER,      P_ROOT, P_ROOT};
            P_ROOT:  w = '{A_ROOT,   C_ROOT_END,  P_EMIT,  C_ROOT_START, P_EDGE, P_ROOT};
            P_EDGE:  w = '{A_EDGE,   C_BACK,      P_TRACE, C_LAST_POP,   P_ROOT, P_EDGE};
            P_TRACE: w = '{A_TRACE,  C_TRACE_HIT, P_FOUND, C_NEVER,      P_TRACE, P_TRACE};
            P_FOUND: w = '{A_FOUND,  C_NEVER,     P_EMIT,  C_NEVER,      P_EMIT, P_EMIT};
            P_EMIT:  w = '{A_EMIT,   C_OUT_BUSY,  P_EMIT,  C_NEVER,      P_WAIT, P_WAIT};
            default: w = '{A_NONE,   C_NEVER,     P_WAIT,  C_NEVER,      P_WAIT, P_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/asc_useq.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control ROM with two prioritized conditional jumps.
// ----------------------------------------------------------------------------
module asc_useq (
    input  logic          aclk,
    input  logic          aresetn,
    input  asc_pkg::cond_t cond,
    output asc_pkg::ctrl_t ctrl
);
    import asc_pkg::*;

    upc_t  pc_reg;
    upc_t  pc_next;
    ctrl_t word;

    function automatic logic pick(cond_sel_t s, cond_t c);
        logic r;
        unique case (s)
            C_NEVER:      r = 1'b0;
            C_IN_VALID:   r = c.in_valid;
            C_ACTIVATE:   r = c.activate;
            C_FEW:        r = c.few;
            C_ROOT_END:   r = c.root_end;
            C_ROOT_START: r = c.root_start;
            C_BACK:       r = c.back;
            C_LAST_POP:   r = c.last_pop;
            C_TRACE_HIT:  r = c.trace_hit;
            C_OUT_BUSY:   r = c.out_busy;
            default:      r = 1'b0;
        endcase
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= P_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    always_comb begin
        word = ucode(pc_reg);
        if (pick(word.c1, cond)) begin
            pc_next = word.t1;
        end else if (pick(word.c2, cond)) begin
            pc_next = word.t2;
        end else begin
            pc_next = word.tn;
        end
    end

    assign ctrl = word;

endmodule

FILE: sv/active_set_cycle_detector.sv
// ----------------------------------------------------------------------------
// Active-set cycle detector
// Per-timestep active node sets with a depth-first cycle search after each
// activation, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each input transaction activates a node in one timestep's active set, removes
// one, or changes nothing, and always yields exactly one output transaction.
// After an activation the block searches the updated set for a directed cycle
// over the configured interference graph: roots are taken from the lowest
// unvisited node upward, neighbours in ascending order, self edges skipped, and
// the first back edge found gives the cycle, reported as a member mask together
// with a saturating 16-bit count of cycles seen so far. The search is run by a
// small microprogram that tests one candidate edge per clock. An activation
// steps through the candidate roots and, for each node entered, through its
// candidate neighbours; when a cycle is found the scan stops early, and the
// path is traced back member by member before the cycle is counted. Only one
// item is in the block at a time, but the next one is taken while the previous
// result still waits in the output register. The interference rows may be
// written only while the block is idle.
// The active sets live in a STEP_COUNT-entry memory with one valid bit per
// entry, so reset clears them at once with no clearing pass.
// ----------------------------------------------------------------------------
`include "active_set_cycle_detector_macros.svh"

module active_set_cycle_detector #(
    parameter int NODE_COUNT = asc_pkg::NODE_COUNT_DEF,
    parameter int STEP_COUNT = asc_pkg::STEP_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port: one interference row per index.
    input  logic                            cfg_wr_en,
    input  logic [asc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asc_pkg::MAX_NODES-1:0]   cfg_wdata,
    // Input stream. tdata: operation[1:0], step_index[5:2], node[8:6], zero fill.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [asc_pkg::S_DATA_W-1:0]    s_tdata,
    // Result stream. tdata: cycle_found[0], cycle_members[8:1],
    // cycles_total[24:9], zero fill.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [asc_pkg::M_DATA_W-1:0]    m_tdata
);
    import asc_pkg::*;

    localparam int SIDX_W = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
    localparam logic [MAX_NODES-1:0] NODE_MASK = MAX_NODES'((1 << NODE_COUNT) - 1);
    localparam logic [CNT_W-1:0]     NODE_END  = CNT_W'(NODE_COUNT);

    cond_t cond;
    ctrl_t ctrl;
    act_t  act;

    // Input transaction fields.
    logic [OP_W-1:0]      op_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [NODE_W-1:0]    node_reg;

    // Active-set memory with valid bits (invalid entries read as empty).
    logic [MAX_NODES-1:0] set_mem [STEP_COUNT];
    logic [STEP_COUNT-1:0] valid_reg;
    logic [MAX_NODES-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [SIDX_W-1:0]    rd_addr;
    logic [SIDX_W-1:0]    wr_addr;
    logic                 mem_we;

    // Interference rows.
    logic [MAX_NODES-1:0] rows_reg [MAX_NODES];

    // Search datapath.
    logic [MAX_NODES-1:0] set_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [MAX_NODES-1:0] onpath_reg;
    logic [NODE_W-1:0]    path_reg [MAX_NODES];
    logic [CNT_W-1:0]     nbr_reg  [MAX_NODES];
    logic [CNT_W-1:0]     depth_reg;
    logic [CNT_W-1:0]     root_reg;
    logic [NODE_W-1:0]    tidx_reg;
    logic [MAX_NODES-1:0] members_reg;
    logic                 found_reg;
    logic [TOTAL_W-1:0]   cnt_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    logic                 accept;
    logic                 in_range;
    logic [MAX_NODES-1:0] cur_set;
    logic [MAX_NODES-1:0] node_bit;
    logic [MAX_NODES-1:0] set_new;
    logic [CNT_W-1:0]     pop;
    logic [NODE_W-1:0]    root_idx;
    logic [NODE_W-1:0]    top_idx;
    logic [NODE_W-1:0]    rd_idx;
    logic [NODE_W-1:0]    path_node;
    logic [CNT_W-1:0]     nbr_cnt;
    logic [NODE_W-1:0]    other;
    logic                 exhausted;
    logic                 edge_ok;
    logic                 descend;
    logic                 push_en;
    logic [NODE_W-1:0]    push_node;

    asc_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctrl    (ctrl)
    );

    assign act      = ctrl.act;
    assign s_tready = (act == A_ACCEPT);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign rd_addr = SIDX_W'(s_tdata[OP_W +: STEP_W]);
    assign wr_addr = SIDX_W'(step_reg);

    // Update of the addressed set.
    always_comb begin
        in_range = (32'(step_reg) < STEP_COUNT) && (32'(node_reg) < NODE_COUNT);
        cur_set  = rd_valid_reg ? rd_data_reg : '0;
        node_bit = MAX_NODES'(1) << node_reg;
        case (op_reg)
            OP_ACTIVATE: set_new = cur_set | node_bit;
            OP_UNDO:     set_new = cur_set & ~node_bit;
            default:     set_new = cur_set;
        endcase
        mem_we = (act == A_UPDATE) && in_range &&
                 ((op_reg == OP_ACTIVATE) || (op_reg == OP_UNDO));
    end

    always_comb begin
        pop = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            pop = pop + CNT_W'(set_reg[i]);
        end
    end

    // Edge test: the top of the path stack against its next neighbour candidate.
    // During the trace the single path read port follows the trace index.
    always_comb begin
        root_idx  = root_reg[NODE_W-1:0];
        top_idx   = depth_reg[NODE_W-1:0] - NODE_W'(1);
        rd_idx    = (act == A_TRACE) ? tidx_reg : top_idx;
        path_node = path_reg[rd_idx];
        nbr_cnt   = nbr_reg[top_idx];
        other     = nbr_cnt[NODE_W-1:0];
        exhausted = (nbr_cnt == NODE_END);
        edge_ok   = !exhausted && (other != path_node) && set_reg[other] &&
                    rows_reg[path_node][other];
        descend   = edge_ok && !onpath_reg[other] && !visited_reg[other];

        cond.in_valid   = s_tvalid;
        cond.activate   = in_range && (op_reg == OP_ACTIVATE);
        cond.few        = (pop < CNT_W'(2));
        cond.root_end   = (root_reg == NODE_END);
        cond.root_start = (root_reg != NODE_END) && set_reg[root_idx] &&
                          !visited_reg[root_idx];
        cond.back       = edge_ok && onpath_reg[other];
        cond.last_pop   = exhausted && (depth_reg == CNT_W'(1));
        cond.trace_hit  = (path_node == other);
        cond.out_busy   = out_valid_reg && !m_tready;

        push_en   = 1'b0;
        push_node = other;
        if (act == A_ROOT) begin
            push_en   = cond.root_start;
            push_node = root_idx;
        end else if (act == A_EDGE) begin
            push_en   = descend;
        end
    end

    // Memory: written after the set update, read on the accepting edge.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            set_mem[wr_addr] <= set_new;
        end
        if (accept) begin
            rd_data_reg <= set_mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            depth_reg     <= '0;
            visited_reg   <= '0;
            onpath_reg    <= '0;
            for (int i = 0; i < MAX_NODES; i++) begin
                rows_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                rows_reg[cfg_index] <= cfg_wdata;
            end
            if (mem_we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if ((act == A_EMIT) && !cond.out_busy) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if ((act == A_FOUND) && (cnt_reg != COUNTER_MAX)) begin
                cnt_reg <= cnt_reg + TOTAL_W'(1);
            end
            if (act == A_CLEAR) begin
                depth_reg   <= '0;
                visited_reg <= '0;
                onpath_reg  <= '0;
            end else if ((act == A_EDGE) && exhausted) begin
                onpath_reg[path_node] <= 1'b0;
                depth_reg             <= depth_reg - CNT_W'(1);
            end else if (push_en) begin
                visited_reg[push_node] <= 1'b1;
                onpath_reg[push_node]  <= 1'b1;
                depth_reg              <= depth_reg + CNT_W'(1);
            end
        end
    end

    // Payload and scan registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_tdata[0 +: OP_W];
            step_reg     <= s_tdata[OP_W +: STEP_W];
            node_reg     <= s_tdata[OP_W + STEP_W +: NODE_W];
            rd_valid_reg <= valid_reg[rd_addr];
            found_reg    <= 1'b0;
            members_reg  <= '0;
        end
        if (act == A_UPDATE) begin
            set_reg <= set_new & NODE_MASK;
        end
        if (act == A_CLEAR) begin
            root_reg <= '0;
        end
        if ((act == A_ROOT) && !cond.root_end) begin
            root_reg <= root_reg + CNT_W'(1);
        end
        if ((act == A_EDGE) && !exhausted) begin
            if (cond.back) begin
                tidx_reg <= top_idx;
            end else begin
                nbr_reg[top_idx] <= nbr_cnt + CNT_W'(1);
            end
        end
        if (push_en) begin
            path_reg[depth_reg[NODE_W-1:0]] <= push_node;
            nbr_reg[depth_reg[NODE_W-1:0]]  <= '0;
        end
        if (act == A_TRACE) begin
            members_reg[path_node] <= 1'b1;
            tidx_reg               <= tidx_reg - NODE_W'(1);
        end
        if (act == A_FOUND) begin
            found_reg <= 1'b1;
        end
        if ((act == A_EMIT) && !cond.out_busy) begin
            out_data_reg <= M_DATA_W'({cnt_reg, members_reg, found_reg});
        end
    end

    // The path never grows beyond the number of nodes.
    `ASC_ASSERT_ALWAYS(a_depth_bound, depth_reg <= NODE_END)
    // Every node on the current path has been visited.
    `ASC_ASSERT_ALWAYS(a_path_visited, (onpath_reg & ~visited_reg) == '0)
    // A reported cycle has at least two members, since self edges are skipped.
    `ASC_ASSERT_IMP(a_cycle_size, out_valid_reg && out_data_reg[0],
                    $countones(out_data_reg[MAX_NODES:1]) >= 2)
    // The cycle counter only moves up.
    `ASC_ASSERT_NXT(a_count_monotonic, 1'b1, cnt_reg >= $past(cnt_reg))
    // The path trace ends only by reaching the back-edge target.
    `ASC_ASSERT_NXT(a_trace_exit, act == A_TRACE, (act == A_TRACE) || (act == A_FOUND))

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Active-set cycle detector testbench
// Drives activate, undo and no-change transactions into the input stream,
// tracks every timestep's active set and the interference graph in a local
// predictor, and checks each result transaction field by field in order.
// ----------------------------------------------------------------------------
// The run opens with a short directed table and then runs six random phases.
// Directed rows cover the reset state, both step and node extremes, every
// operation including the unused code, the empty and the complete graph, and
// a ring that only closes on its last activation. Where a row's result is
// obvious, it is typed into the table. All other rows, and all random
// transactions, take their expectation from the predictor.
//
// The interference rows are written only while the block is idle, which means
// no expected result is still outstanding. Each random phase loads a new graph
// first. The graphs are the empty graph, the complete graph, sparse graphs that
// give short cycles, and dense random graphs. The first third of the run
// throttles the sender lightly and the receiver heavily. The second third
// swaps the two. The last third runs both sides at full rate.
// ----------------------------------------------------------------------------
module tb;
    import asc_pkg::*;

    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 105;
    localparam int DIR_ROWS         = 24;
    localparam int DRAIN_CYCLES     = 100;
    // The search time of an activation and a long receiver stall both count as
    // idle, so reaching this limit can only mean a hang.
    localparam int STALL_LIMIT      = 2000;

    // Operation code 3 is not defined. The block must treat it as no change.
    localparam logic [OP_W-1:0]      OP_SPARE     = 2'd3;
    // The interference rows sit at consecutive register indexes.
    localparam logic [CFG_IDX_W-1:0] ROW_REG_BASE = 3'd0;

    localparam logic [7:0][7:0] GRAPH_FULL = {8{8'hFF}};
    // Each node has a self edge and an edge to the next node, wrapping around.
    localparam logic [7:0][7:0] GRAPH_RING =
        {8'h81, 8'hC0, 8'h60, 8'h30, 8'h18, 8'h0C, 8'h06, 8'h03};

    typedef struct packed {
        logic [2:0]      node;
        logic [STEP_W-1:0] step;
        logic [OP_W-1:0] op;
    } action_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]   total;
        logic [MAX_NODES-1:0] members;
        logic                 found;
    } cycle_report_t;

    typedef enum logic [1:0] {ROW_PREDICTED, ROW_TYPED, ROW_GRAPH} row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        action_t         act;
        cycle_report_t   want;
        logic [7:0][7:0] graph;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MAX_NODES-1:0] cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    // Predictor state: the graph as written, one active set per timestep, and
    // the saturating count of cycles found.
    logic [MAX_NODES-1:0] graph_rows [MAX_NODES];
    logic [MAX_NODES-1:0] step_sets [STEP_COUNT_DEF];
    logic [TOTAL_W-1:0]   cycles_seen;

    cycle_report_t pending_reports [$];
    dir_row_t      dir_table [DIR_ROWS];
    int            tx_gap_pct;
    int            rx_stall_pct;
    int            err_count;
    int            idle_cycles;

    always #6 aclk = ~aclk;

    active_set_cycle_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Depth-first search over one active set. It starts at the lowest
    // unvisited node, tries neighbors in ascending order and skips self edges.
    // The first edge back onto the current path closes the cycle. The members
    // are the path from the target of that edge down to the current node.
    // An explicit stack replaces recursion. next_try keeps, per depth, the
    // next neighbor that is still to be tried.
    function automatic bit trace_cycle(input logic [MAX_NODES-1:0] set,
                                       output logic [MAX_NODES-1:0] members);
        logic [MAX_NODES-1:0] visited;
        logic [MAX_NODES-1:0] on_path;
        int path [MAX_NODES];
        int next_try [MAX_NODES];
        int depth;
        int cur;
        int nb;
        int k;
        members = '0;
        if ($countones(set) < 2)
            return 1'b0;
        visited = '0;
        on_path = '0;
        for (int root = 0; root < MAX_NODES; root++) begin
            if (set[root] && !visited[root]) begin
                visited[root] = 1'b1;
                on_path[root] = 1'b1;
                path[0] = root;
                next_try[0] = 0;
                depth = 1;
                while (depth > 0) begin
                    cur = path[depth-1];
                    nb = next_try[depth-1];
                    if (nb == MAX_NODES) begin
                        on_path[cur] = 1'b0;
                        depth--;
                    end else begin
                        next_try[depth-1] = nb + 1;
                        if (nb != cur && set[nb] && graph_rows[cur][nb]) begin
                            if (on_path[nb]) begin
                                k = 0;
                                while (path[k] != nb)
                                    k++;
                                while (k < depth) begin
                                    members[path[k]] = 1'b1;
                                    k++;
                                end
                                return 1'b1;
                            end
                            if (!visited[nb]) begin
                                visited[nb] = 1'b1;
                                on_path[nb] = 1'b1;
                                path[depth] = nb;
                                next_try[depth] = 0;
                                depth++;
                            end
                        end
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one accepted transaction to the predictor and returns the
    // result that the block must produce for it.
    function automatic cycle_report_t apply_action(input action_t a);
        cycle_report_t        rep;
        logic [MAX_NODES-1:0] members;
        rep = '0;
        if (a.op == OP_ACTIVATE) begin
            step_sets[a.step][a.node] = 1'b1;
            if (trace_cycle(step_sets[a.step], members)) begin
                rep.found = 1'b1;
                rep.members = members;
                if (cycles_seen != COUNTER_MAX)
                    cycles_seen++;
            end
        end else if (a.op == OP_UNDO) begin
            step_sets[a.step][a.node] = 1'b0;
        end
        rep.total = cycles_seen;
        return rep;
    endfunction

    function automatic dir_row_t typed_row(input logic [OP_W-1:0] op, input int step,
                                           input int node, input logic found,
                                           input logic [7:0] members, input int total);
        dir_row_t r;
        r = '0;
        r.kind = ROW_TYPED;
        r.act = '{node: 3'(node), step: STEP_W'(step), op: op};
        r.want = '{total: TOTAL_W'(total), members: members, found: found};
        return r;
    endfunction

    function automatic dir_row_t predicted_row(input logic [OP_W-1:0] op, input int step,
                                               input int node);
        dir_row_t r;
        r = '0;
        r.kind = ROW_PREDICTED;
        r.act = '{node: 3'(node), step: STEP_W'(step), op: op};
        return r;
    endfunction

    function automatic dir_row_t graph_row(input logic [7:0][7:0] graph);
        dir_row_t r;
        r = '0;
        r.kind = ROW_GRAPH;
        r.graph = graph;
        return r;
    endfunction

    // Presents one input transaction. While the sender's gap rate fires, tvalid
    // is first held low. The task returns at the edge that
    // accepted the transaction, with tvalid still high, so that the next
    // transaction can follow on the very next cycle.
    task automatic send_action(input action_t a, input bit typed,
                               input cycle_report_t want);
        cycle_report_t rep;
        cfg_wr_en <= 1'b0;
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, a};
        do @(posedge aclk); while (!s_tready);
        rep = apply_action(a);
        pending_reports = {pending_reports, (typed ? want : rep)};
    endtask

    // Waits until every outstanding result has arrived, then writes all eight
    // interference rows on consecutive cycles. The write enable stays high
    // after the last row. The next transaction or the end of the run lowers
    // it.
    task automatic write_graph(input logic [7:0][7:0] graph);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        for (int i = 0; i < MAX_NODES; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ROW_REG_BASE + CFG_IDX_W'(i);
            cfg_wdata <= graph[i];
            graph_rows[i] = graph[i];
            @(posedge aclk);
        end
    endtask

    // Result side. It applies random backpressure and checks every accepted
    // transaction against the oldest expectation.
    always @(posedge aclk) begin
        cycle_report_t got;
        cycle_report_t exp_rep;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(cycle_report_t)-1:0];
                if (pending_reports.size() == 0) begin
                    $error("result transaction with no expectation waiting: %h", m_tdata);
                    err_count++;
                end else begin
                    exp_rep = pending_reports.pop_front();
                    if (got.found !== exp_rep.found) begin
                        $error("cycle_found: expected %0d, got %0d",
                               exp_rep.found, got.found);
                        err_count++;
                    end
                    if (got.members !== exp_rep.members) begin
                        $error("cycle_members: expected %h, got %h",
                               exp_rep.members, got.members);
                        err_count++;
                    end
                    if (got.total !== exp_rep.total) begin
                        $error("cycles_total: expected %0d, got %0d",
                               exp_rep.total, got.total);
                        err_count++;
                    end
                end
            end
        end
    end

    // The watchdog counts the cycles in which neither stream nor the
    // configuration port moves anything.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        action_t         act;
        logic [7:0][7:0] graph;
        int              roll;

        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cycles_seen = '0;
        foreach (graph_rows[i])
            graph_rows[i] = '0;
        foreach (step_sets[i])
            step_sets[i] = '0;
        tx_gap_pct   = 11;
        rx_stall_pct = 47;

        // The first rows run on the reset graph, which has no edges, so no
        // activation can close a cycle. With the complete graph, any two active
        // nodes form a cycle through the lowest of them. On the ring, the cycle
        // closes only when the last node comes in. It then closes again after
        // a node is removed and put back.
        dir_table = '{
            typed_row(OP_ACTIVATE, 0, 0, 1'b0, 8'h00, 0),
            typed_row(OP_ACTIVATE, 15, 7, 1'b0, 8'h00, 0),
            typed_row(OP_ACTIVATE, 0, 1, 1'b0, 8'h00, 0),
            typed_row(OP_FALSE, 0, 2, 1'b0, 8'h00, 0),
            typed_row(OP_SPARE, 15, 7, 1'b0, 8'h00, 0),
            typed_row(OP_UNDO, 15, 7, 1'b0, 8'h00, 0),
            graph_row(GRAPH_FULL),
            typed_row(OP_ACTIVATE, 0, 2, 1'b1, 8'h03, 1),
            typed_row(OP_ACTIVATE, 15, 7, 1'b0, 8'h00, 1),
            typed_row(OP_ACTIVATE, 15, 0, 1'b1, 8'h81, 2),
            typed_row(OP_UNDO, 0, 0, 1'b0, 8'h00, 2),
            predicted_row(OP_ACTIVATE, 0, 3),
            graph_row(GRAPH_RING),
            predicted_row(OP_ACTIVATE, 1, 0),
            predicted_row(OP_ACTIVATE, 1, 1),
            predicted_row(OP_ACTIVATE, 1, 2),
            predicted_row(OP_ACTIVATE, 1, 3),
            predicted_row(OP_ACTIVATE, 1, 4),
            predicted_row(OP_ACTIVATE, 1, 5),
            predicted_row(OP_ACTIVATE, 1, 6),
            predicted_row(OP_ACTIVATE, 1, 7),
            predicted_row(OP_UNDO, 1, 3),
            predicted_row(OP_ACTIVATE, 1, 3),
            predicted_row(OP_FALSE, 1, 5)
        };

        // Reset is applied once.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_GRAPH)
                write_graph(dir_table[i].graph);
            else
                send_action(dir_table[i].act, dir_table[i].kind == ROW_TYPED,
                            dir_table[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p / 2)
                0: begin
                    tx_gap_pct   = 11;
                    rx_stall_pct = 47;
                end
                1: begin
                    tx_gap_pct   = 47;
                    rx_stall_pct = 11;
                end
                default: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
            endcase

            // Sparse rows (about one edge in four) give short cycles that
            // appear and vanish as nodes come and go. Dense rows close a cycle
            // almost at once. The empty and the complete graph are the two
            // extremes.
            for (int i = 0; i < MAX_NODES; i++) begin
                case (p)
                    0:       graph[i] = 8'h00;
                    3:       graph[i] = 8'hFF;
                    1, 4:    graph[i] = 8'($urandom & $urandom);
                    default: graph[i] = 8'($urandom);
                endcase
            end
            write_graph(graph);

            // Activations dominate, so the sets fill up. Removals keep them
            // from saturating. Most transactions go to a few timesteps so that
            // their sets grow large enough to hold cycles.
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    act.op = OP_ACTIVATE;
                else if (roll < 80)
                    act.op = OP_UNDO;
                else if (roll < 90)
                    act.op = OP_FALSE;
                else
                    act.op = OP_SPARE;
                act.step = ($urandom_range(0, 99) < 75) ? STEP_W'($urandom_range(0, 3))
                                                        : STEP_W'($urandom_range(0, 15));
                act.node = 3'($urandom_range(0, 7));
                send_action(act, 1'b0, '0);
            end
        end

        s_tvalid  <= 1'b0;
        cfg_wr_en <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        // A final drain lets any stray result transaction show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/asc_pkg.sv
sv/asc_useq.sv
sv/active_set_cycle_detector.sv
tb/tb.sv
